// ===== sv/pwcr_pkg.sv =====
package pwcr_pkg;

   localparam int PULSE_COUNT_BITS_DEF = 4;
   localparam int FRAME_BITS_DEF       = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_MIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_MIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_MAX      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PHOTO_CODE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FOCUS_CODE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_CODE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_TICKS = 3'd6;

   localparam logic [3:0] SHORT_MIN_RST     = 4'd3;
   localparam logic [3:0] LONG_MIN_RST      = 4'd7;
   localparam logic [4:0] LONG_MAX_RST      = 5'd10;
   localparam logic [7:0] PHOTO_CODE_RST    = 8'd1;
   localparam logic [7:0] FOCUS_CODE_RST    = 8'd2;
   localparam logic [7:0] RELEASE_CODE_RST  = 8'd3;
   localparam logic [9:0] RELEASE_TICKS_RST = 10'd256;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_PHOTO   = 2'd1,
      CMD_FOCUS   = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [3:0] short_min;
      logic [3:0] long_min;
      logic [4:0] long_max;
      logic [7:0] photo_code;
      logic [7:0] focus_code;
      logic [7:0] release_code;
      logic [9:0] release_ticks;
   } cfg_type;

   typedef struct packed {
      logic       photo_drive;
      logic       focus_drive;
      logic       byte_done;
      logic [7:0] received_byte;
      cmd_type    matched_command;
   } result_type;

endpackage

// ===== sv/pwcr_core.sv =====
module pwcr_core #(
   parameter int PULSE_COUNT_BITS = pwcr_pkg::PULSE_COUNT_BITS_DEF,
   parameter int FRAME_BITS       = pwcr_pkg::FRAME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 line_high,
   input  logic                 timer_tick,
   input  pwcr_pkg::cfg_type    cfg,
   output pwcr_pkg::result_type result
);

   localparam int BCW   = $clog2(FRAME_BITS + 1);
   localparam int BCX   = (BCW > 4) ? BCW : 4;
   localparam int CMP_W = (PULSE_COUNT_BITS > 5) ? PULSE_COUNT_BITS : 5;

   logic [PULSE_COUNT_BITS-1:0] pulse_count_ff, pulse_count_in;
   logic [BCW-1:0]              bit_count_ff, bit_count_in;
   logic [7:0]                  shift_byte_ff, shift_byte_in;
   logic                        photo_active_ff, photo_active_in;
   logic                        focus_active_ff, focus_active_in;
   logic                        timer_running_ff, timer_running_in;
   logic [9:0]                  timer_value_ff, timer_value_in;

   logic [CMP_W-1:0] count_ext;
   logic [BCX-1:0]   bit_ext;
   logic [7:0]       shown;
   logic             done;
   pwcr_pkg::cmd_type cmd;

   assign count_ext = CMP_W'(pulse_count_ff);
   assign bit_ext   = BCX'(bit_count_ff);

   always_comb begin
      timer_value_in   = timer_value_ff;
      timer_running_in = timer_running_ff;
      photo_active_in  = photo_active_ff;
      focus_active_in  = focus_active_ff;
      pulse_count_in   = pulse_count_ff;
      bit_count_in     = bit_count_ff;
      shift_byte_in    = shift_byte_ff;
      done             = 1'b0;
      cmd              = pwcr_pkg::CMD_NONE;

      if (timer_tick && timer_running_ff) begin
         timer_value_in = timer_value_ff + 10'd1;
         if (timer_value_in >= cfg.release_ticks) begin
            photo_active_in  = 1'b0;
            focus_active_in  = 1'b0;
            timer_running_in = 1'b0;
         end
      end

      if (line_high) begin
         pulse_count_in = pulse_count_ff + 1'b1;
      end else if (pulse_count_ff != '0) begin
         pulse_count_in = '0;
         if (count_ext < CMP_W'(cfg.short_min) || count_ext >= CMP_W'(cfg.long_max)) begin
            shift_byte_in = '0;
            bit_count_in  = '0;
         end else begin
            for (int i = 0; i < 8; i++) begin
               if (count_ext < CMP_W'(cfg.long_min) && bit_ext == BCX'(i)) begin
                  shift_byte_in[i] = 1'b1;
               end
            end
            bit_count_in = bit_count_ff + 1'b1;
         end
      end

      shown = shift_byte_in;

      if (bit_count_in >= BCW'(FRAME_BITS)) begin
         done = 1'b1;
         priority if (shown == cfg.photo_code) begin
            cmd              = pwcr_pkg::CMD_PHOTO;
            photo_active_in  = 1'b1;
            focus_active_in  = 1'b1;
            timer_value_in   = '0;
            timer_running_in = 1'b1;
         end else if (shown == cfg.focus_code) begin
            cmd              = pwcr_pkg::CMD_FOCUS;
            focus_active_in  = 1'b1;
            timer_value_in   = '0;
            timer_running_in = 1'b1;
         end else if (shown == cfg.release_code) begin
            cmd              = pwcr_pkg::CMD_RELEASE;
            photo_active_in  = 1'b0;
            focus_active_in  = 1'b0;
            timer_running_in = 1'b0;
         end else begin
            cmd = pwcr_pkg::CMD_NONE;
         end
         shift_byte_in = '0;
         bit_count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff   <= '0;
         bit_count_ff     <= '0;
         shift_byte_ff    <= '0;
         photo_active_ff  <= 1'b0;
         focus_active_ff  <= 1'b0;
         timer_running_ff <= 1'b0;
         timer_value_ff   <= '0;
      end else if (accept) begin
         pulse_count_ff   <= pulse_count_in;
         bit_count_ff     <= bit_count_in;
         shift_byte_ff    <= shift_byte_in;
         photo_active_ff  <= photo_active_in;
         focus_active_ff  <= focus_active_in;
         timer_running_ff <= timer_running_in;
         timer_value_ff   <= timer_value_in;
      end
   end

   assign result.photo_drive     = photo_active_in;
   assign result.focus_drive     = focus_active_in;
   assign result.byte_done       = done;
   assign result.received_byte   = shown;
   assign result.matched_command = cmd;

endmodule

// ===== sv/pulse_width_command_receiver_unit.sv =====
// Output: each result is registered and appears on rsp_ in the cycle after its request transaction.
// Throughput: one transaction per cycle; the single result register frees
//   itself in the cycle it is taken, so req_tready stays high while rsp_tready is.
// Reset: synchronous, active high; clears the decoder state, the result valid
//   and loads the configuration registers with their default values.
module pulse_width_command_receiver_unit #(
   parameter int PULSE_COUNT_BITS = pwcr_pkg::PULSE_COUNT_BITS_DEF,
   parameter int FRAME_BITS       = pwcr_pkg::FRAME_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // line_high, timer_tick
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,  // photo_drive, focus_drive,
                                                        // received_byte, matched_command
   output logic                             rsp_tlast,  // byte_done
   input  logic                             csr_we,
   input  logic [pwcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwcr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pwcr_pkg::cfg_type    cfg_ff;
   pwcr_pkg::result_type result;
   pwcr_pkg::result_type rsp_ff;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic                 accept;

   assign req_tready    = !rsp_tvalid_ff || rsp_tready;
   assign accept        = req_tvalid && req_tready;
   assign rsp_tvalid_in = accept || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_min     <= pwcr_pkg::SHORT_MIN_RST;
         cfg_ff.long_min      <= pwcr_pkg::LONG_MIN_RST;
         cfg_ff.long_max      <= pwcr_pkg::LONG_MAX_RST;
         cfg_ff.photo_code    <= pwcr_pkg::PHOTO_CODE_RST;
         cfg_ff.focus_code    <= pwcr_pkg::FOCUS_CODE_RST;
         cfg_ff.release_code  <= pwcr_pkg::RELEASE_CODE_RST;
         cfg_ff.release_ticks <= pwcr_pkg::RELEASE_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pwcr_pkg::REG_SHORT_MIN:     cfg_ff.short_min     <= csr_wdata[3:0];
            pwcr_pkg::REG_LONG_MIN:      cfg_ff.long_min      <= csr_wdata[3:0];
            pwcr_pkg::REG_LONG_MAX:      cfg_ff.long_max      <= csr_wdata[4:0];
            pwcr_pkg::REG_PHOTO_CODE:    cfg_ff.photo_code    <= csr_wdata[7:0];
            pwcr_pkg::REG_FOCUS_CODE:    cfg_ff.focus_code    <= csr_wdata[7:0];
            pwcr_pkg::REG_RELEASE_CODE:  cfg_ff.release_code  <= csr_wdata[7:0];
            pwcr_pkg::REG_RELEASE_TICKS: cfg_ff.release_ticks <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   pwcr_core #(
      .PULSE_COUNT_BITS (PULSE_COUNT_BITS),
      .FRAME_BITS       (FRAME_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .line_high  (req_tdata[0]),
      .timer_tick (req_tdata[1]),
      .cfg        (cfg_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_ff.byte_done;
   assign rsp_tdata  = {4'b0000, rsp_ff.matched_command, rsp_ff.received_byte,
                        rsp_ff.focus_drive, rsp_ff.photo_drive};

endmodule

// ===== verif/pwcr_command_checker.sv =====
module pwcr_command_checker import pwcr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,  // line_high, timer_tick
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [15:0]            rsp_tdata,  // photo_drive, focus_drive,
                                              // received_byte, matched_command
   input  logic                   rsp_tlast,  // byte_done
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   cfg_type                         cfg;
   logic [PULSE_COUNT_BITS_DEF-1:0] pulse_cnt;
   logic [3:0]                      bit_cnt;
   logic [7:0]                      shift_reg;
   logic                            photo_on;
   logic                            focus_on;
   logic                            timer_on;
   logic [9:0]                      timer_val;
   result_type                      predicted_outputs[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic release_outputs();
      photo_on = 1'b0;
      focus_on = 1'b0;
      timer_on = 1'b0;
   endtask

   task automatic decode_sample(input logic line, input logic tick, output result_type r);
      logic [PULSE_COUNT_BITS_DEF-1:0] width;
      logic [7:0]                      shown;
      r = '0;
      r.matched_command = CMD_NONE;
      if (tick && timer_on) begin
         timer_val = timer_val + 10'd1;
         if (timer_val >= cfg.release_ticks)
            release_outputs();
      end
      if (line) begin
         pulse_cnt = pulse_cnt + 1'b1;
      end else if (pulse_cnt != '0) begin
         width     = pulse_cnt;
         pulse_cnt = '0;
         if (width < cfg.short_min || width >= cfg.long_max) begin
            shift_reg = '0;
            bit_cnt   = '0;
         end else begin
            if (width < cfg.long_min && bit_cnt < 4'd8)
               shift_reg[bit_cnt[2:0]] = 1'b1;
            bit_cnt++;
         end
      end
      shown = shift_reg;
      r.received_byte = shown;
      if (bit_cnt >= FRAME_BITS_DEF) begin
         r.byte_done = 1'b1;
         if (shown == cfg.photo_code) begin
            r.matched_command = CMD_PHOTO;
            photo_on  = 1'b1;
            focus_on  = 1'b1;
            timer_on  = 1'b1;
            timer_val = '0;
         end else if (shown == cfg.focus_code) begin
            r.matched_command = CMD_FOCUS;
            focus_on  = 1'b1;
            timer_on  = 1'b1;
            timer_val = '0;
         end else if (shown == cfg.release_code) begin
            r.matched_command = CMD_RELEASE;
            release_outputs();
         end
         shift_reg = '0;
         bit_cnt   = '0;
      end
      r.photo_drive = photo_on;
      r.focus_drive = focus_on;
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         cfg.short_min     = SHORT_MIN_RST;
         cfg.long_min      = LONG_MIN_RST;
         cfg.long_max      = LONG_MAX_RST;
         cfg.photo_code    = PHOTO_CODE_RST;
         cfg.focus_code    = FOCUS_CODE_RST;
         cfg.release_code  = RELEASE_CODE_RST;
         cfg.release_ticks = RELEASE_TICKS_RST;
         pulse_cnt = '0;
         bit_cnt   = '0;
         shift_reg = '0;
         timer_val = '0;
         release_outputs();
         predicted_outputs.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SHORT_MIN:     cfg.short_min     = csr_wdata[3:0];
               REG_LONG_MIN:      cfg.long_min      = csr_wdata[3:0];
               REG_LONG_MAX:      cfg.long_max      = csr_wdata[4:0];
               REG_PHOTO_CODE:    cfg.photo_code    = csr_wdata[7:0];
               REG_FOCUS_CODE:    cfg.focus_code    = csr_wdata[7:0];
               REG_RELEASE_CODE:  cfg.release_code  = csr_wdata[7:0];
               REG_RELEASE_TICKS: cfg.release_ticks = csr_wdata[9:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_outputs.size() == 0) begin
               report_mismatch("unexpected transaction", int'(rsp_tdata), 0);
            end else begin
               want = predicted_outputs.pop_front();
               if (rsp_tdata[0] !== want.photo_drive)
                  report_mismatch("photo_drive", int'(rsp_tdata[0]),
                                  int'(want.photo_drive));
               if (rsp_tdata[1] !== want.focus_drive)
                  report_mismatch("focus_drive", int'(rsp_tdata[1]),
                                  int'(want.focus_drive));
               if (rsp_tlast !== want.byte_done)
                  report_mismatch("byte_done", int'(rsp_tlast), int'(want.byte_done));
               if (rsp_tdata[9:2] !== want.received_byte)
                  report_mismatch("received_byte", int'(rsp_tdata[9:2]),
                                  int'(want.received_byte));
               if (rsp_tdata[11:10] !== want.matched_command)
                  report_mismatch("matched_command", int'(rsp_tdata[11:10]),
                                  int'(want.matched_command));
            end
         end
         if (req_tvalid && req_tready) begin
            decode_sample(req_tdata[0], req_tdata[1], want);
            predicted_outputs.push_back(want);
         end
      end
      pending = predicted_outputs.size();
   end

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import pwcr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // line_high, timer_tick
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [15:0]            rsp_tdata;   // photo_drive, focus_drive,
                                        // received_byte, matched_command
   logic                   rsp_tlast;   // byte_done
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int                     fail_count;
   int                     pending;
   int unsigned            cycle_count = 0;
   int                     phase_samples;
   int                     tick_pct;
   bit                     req_quiet;
   bit                     rsp_quiet;
   cfg_type                cur_cfg;

   always #5 clock = ~clock;

   pulse_width_command_receiver_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pwcr_command_checker command_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** pulse_width_command_receiver_unit: FAILED **");
         $finish;
      end
   end

   // switch between bursts with no waits and bursts with random waits
   task automatic draw_wait(inout bit quiet, output int n);
      if ($urandom_range(0, 39) == 0)
         quiet = ~quiet;
      n = quiet ? 0 : $urandom_range(0, 11);
   endtask

   initial begin : result_sink
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         draw_wait(rsp_quiet, stall);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic cfg_type make_cfg(input int sm, input int lmin, input int lmax,
                                        input int pc, input int fc, input int rc,
                                        input int rt);
      cfg_type c;
      c.short_min     = sm[3:0];
      c.long_min      = lmin[3:0];
      c.long_max      = lmax[4:0];
      c.photo_code    = pc[7:0];
      c.focus_code    = fc[7:0];
      c.release_code  = rc[7:0];
      c.release_ticks = rt[9:0];
      return c;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      cur_cfg = c;
      write_reg(REG_SHORT_MIN,     CSR_DATA_W'(c.short_min));
      write_reg(REG_LONG_MIN,      CSR_DATA_W'(c.long_min));
      write_reg(REG_LONG_MAX,      CSR_DATA_W'(c.long_max));
      write_reg(REG_PHOTO_CODE,    CSR_DATA_W'(c.photo_code));
      write_reg(REG_FOCUS_CODE,    CSR_DATA_W'(c.focus_code));
      write_reg(REG_RELEASE_CODE,  CSR_DATA_W'(c.release_code));
      write_reg(REG_RELEASE_TICKS, CSR_DATA_W'(c.release_ticks));
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(input logic line, input logic tick);
      int gap;
      draw_wait(req_quiet, gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, tick, line};
      do @(posedge clock); while (!req_tready);
      phase_samples++;
   endtask

   function automatic logic next_tick();
      return $urandom_range(0, 99) < tick_pct;
   endfunction

   task automatic send_pulse(input int width);
      repeat (width) send_sample(1'b1, next_tick());
      repeat ($urandom_range(1, 3)) send_sample(1'b0, next_tick());
   endtask

   function automatic int bit_width(input logic one);
      int lo, hi;
      if (one) begin
         lo = int'(cur_cfg.short_min);
         hi = int'(cur_cfg.long_min) - 1;
      end else begin
         lo = cur_cfg.short_min > cur_cfg.long_min ? int'(cur_cfg.short_min)
                                                   : int'(cur_cfg.long_min);
         hi = int'(cur_cfg.long_max) - 1;
      end
      if (lo < 1) lo = 1;
      if (hi > 15) hi = 15;
      if (lo > hi)
         return $urandom_range(1, 17);
      return $urandom_range(lo, hi);
   endfunction

   function automatic int invalid_width();
      if (cur_cfg.short_min > 1)
         return $urandom_range(1, int'(cur_cfg.short_min) - 1);
      if (cur_cfg.long_max <= 15)
         return $urandom_range(int'(cur_cfg.long_max), 15);
      return 16;
   endfunction

   // LSB first
   task automatic send_frame(input logic [7:0] value, input int nbits);
      for (int i = 0; i < nbits; i++)
         send_pulse(bit_width(value[i]));
   endtask

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 3))
         0:       return cur_cfg.photo_code;
         1:       return cur_cfg.focus_code;
         2:       return cur_cfg.release_code;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic run_phase(input int target, input int tick_rate);
      int sel;
      tick_pct      = tick_rate;
      phase_samples = 0;
      while (phase_samples < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            send_frame(pick_code(), 8);
         end else if (sel < 75) begin
            send_frame(8'($urandom_range(0, 255)), $urandom_range(1, 7));
            send_pulse(invalid_width());
         end else if (sel < 88) begin
            repeat ($urandom_range(1, 20))
               send_sample(1'($urandom_range(0, 1)), next_tick());
         end else if (sel < 97) begin
            send_pulse($urandom_range(1, 17));
         end else begin
            wait_all_results();
         end
      end
      wait_all_results();
   endtask

   initial begin : stimulus
      int sm, lmin, lmax;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      cur_cfg = make_cfg(int'(SHORT_MIN_RST), int'(LONG_MIN_RST), int'(LONG_MAX_RST),
                         int'(PHOTO_CODE_RST), int'(FOCUS_CODE_RST),
                         int'(RELEASE_CODE_RST), int'(RELEASE_TICKS_RST));
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tick_pct = 50;
      send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b0);
      send_pulse(16);
      send_pulse(12);
      send_pulse(17);
      wait_all_results();

      run_phase(160, 40);

      apply_config(make_cfg(1, 2, 3, 'h00, 'hFF, 'h5A, 1));
      run_phase(160, 30);

      apply_config(make_cfg(15, 15, 16, 'h00, 'h00, 'h00, 1023));
      run_phase(200, 100);

      apply_config(make_cfg(2, 4, 7, 'h3C, 'hC3, 'h3C, 5));
      run_phase(160, 40);

      repeat (2) begin
         sm   = $urandom_range(1, 5);
         lmin = sm + $urandom_range(1, 4);
         lmax = lmin + $urandom_range(1, 4);
         apply_config(make_cfg(sm, lmin, lmax, $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(1, 40)));
         run_phase(160, $urandom_range(10, 60));
      end

      apply_config(make_cfg(1, 1, 1, 'hFF, 'h80, 'h01, 2));
      run_phase(60, 50);

      repeat (3) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** pulse_width_command_receiver_unit: PASSED **");
      else
         $display("** pulse_width_command_receiver_unit: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pwcr_pkg.sv
sv/pwcr_core.sv
sv/pulse_width_command_receiver_unit.sv
verif/pwcr_command_checker.sv
verif/testbench.sv
